// File: rtl/core/weighted_index_sampler_macros.svh
// assertion macros used by the checker file of the weighted index sampler
`ifndef WEIGHTED_INDEX_SAMPLER_MACROS_SVH
`define WEIGHTED_INDEX_SAMPLER_MACROS_SVH

// same-cycle implication on clk_i, disabled while rst_ni is low
`define WIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, disabled while rst_ni is low
`define WIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/wis_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and widths of the weighted index sampler
package wis_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned WGT_W      = 32;
  localparam int unsigned SUM_W      = 42;
  localparam int unsigned ST_W       = 3;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 64;

  typedef logic [SUM_W-1:0] sum_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_UPDATE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SAMPLE = 2'd3
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_FULL      = 3'd3,
    ST_DRAW      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_CHECK    = 4'd1,
    S_PRIOR    = 4'd2,
    S_OLD      = 4'd3,
    S_SWEEP    = 4'd4,
    S_SRCH_RD  = 4'd5,
    S_SRCH_CMP = 4'd6,
    S_RESP     = 4'd7
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    append;
    logic    rd_prior;
    logic    rd_entry;
    logic    delta_init;
    logic    sweep_step;
    logic    commit;
    logic    srch_init;
    logic    srch_rd;
    logic    srch_cmp;
    logic    srch_done;
    logic    status_we;
    status_e status;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    full;
    logic    idx_bad;
    logic    empty;
    logic    draw_big;
    logic    sweep_done;
    logic    srch_done;
    logic    out_free;
  } dp_stat_t;

endpackage

// File: rtl/core/wis_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine of the weighted index sampler
module wis_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wis_pkg::dp_stat_t stat_i,
  output wis_pkg::cmd_t     cmd_o
);

  wis_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wis_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.status = wis_pkg::ST_OK;
    unique case (state_q)
      wis_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = wis_pkg::S_CHECK;
        end
      end
      wis_pkg::S_CHECK: begin
        cmd_o.status_we = 1'b1;
        unique case (stat_i.op)
          wis_pkg::OP_APPEND: begin
            if (stat_i.full) begin
              cmd_o.status = wis_pkg::ST_FULL;
            end else begin
              cmd_o.append = 1'b1;
            end
            state_d = wis_pkg::S_RESP;
          end
          wis_pkg::OP_UPDATE, wis_pkg::OP_REMOVE: begin
            if (stat_i.idx_bad) begin
              cmd_o.status = wis_pkg::ST_BAD_INDEX;
              state_d      = wis_pkg::S_RESP;
            end else begin
              cmd_o.rd_prior = 1'b1;
              state_d        = wis_pkg::S_PRIOR;
            end
          end
          wis_pkg::OP_SAMPLE: begin
            priority if (stat_i.empty) begin
              cmd_o.status = wis_pkg::ST_EMPTY;
              state_d      = wis_pkg::S_RESP;
            end else if (stat_i.draw_big) begin
              cmd_o.status = wis_pkg::ST_DRAW;
              state_d      = wis_pkg::S_RESP;
            end else begin
              cmd_o.srch_init = 1'b1;
              state_d         = wis_pkg::S_SRCH_RD;
            end
          end
        endcase
      end
      wis_pkg::S_PRIOR: begin
        cmd_o.rd_entry = 1'b1;
        state_d        = wis_pkg::S_OLD;
      end
      wis_pkg::S_OLD: begin
        cmd_o.delta_init = 1'b1;
        state_d          = wis_pkg::S_SWEEP;
      end
      wis_pkg::S_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_done) begin
          cmd_o.commit = 1'b1;
          state_d      = wis_pkg::S_RESP;
        end
      end
      wis_pkg::S_SRCH_RD: begin
        if (stat_i.srch_done) begin
          cmd_o.srch_done = 1'b1;
          state_d         = wis_pkg::S_RESP;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d       = wis_pkg::S_SRCH_CMP;
        end
      end
      wis_pkg::S_SRCH_CMP: begin
        cmd_o.srch_cmp = 1'b1;
        state_d        = wis_pkg::S_SRCH_RD;
      end
      wis_pkg::S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = wis_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wis_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/wis_dpath.sv
`timescale 1ns / 1ps
// cumulative-sum memory, sweep and search registers, result register
module wis_dpath #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned WEIGHT_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wis_pkg::cmd_t                 cmd_i,
  output wis_pkg::dp_stat_t             stat_o,
  input  logic [wis_pkg::OP_W-1:0]      in_opcode_i,
  input  logic [wis_pkg::IDX_W-1:0]     in_index_i,
  input  logic [wis_pkg::WGT_W-1:0]     in_weight_i,
  input  logic [wis_pkg::SUM_W-1:0]     in_draw_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wis_pkg::IDX_W-1:0]     out_chosen_o,
  output wis_pkg::status_e              out_status_o,
  output logic [wis_pkg::SUM_W-1:0]     out_total_o,
  output logic [wis_pkg::CNT_W-1:0]     out_count_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned XW = (CW > wis_pkg::CNT_W) ? CW : wis_pkg::CNT_W;
  localparam int unsigned SW = wis_pkg::SUM_W;
  localparam logic [SW-1:0] WMASK =
    (WEIGHT_BITS >= SW) ? {SW{1'b1}} : ((SW'(1) << WEIGHT_BITS) - SW'(1));
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);

  logic [SW-1:0] mem [MAX_ENTRIES];

  wis_pkg::opcode_e op_q;
  logic [XW-1:0]    idx_q;
  wis_pkg::sum_t    wgt_q, draw_q;
  logic [CW-1:0]    count_q;
  wis_pkg::sum_t    total_q;
  wis_pkg::sum_t    rdata_q, prior_q, delta_q;
  logic [CW-1:0]    ptr_q, lo_q, hi_q;
  logic             pv_q;
  logic [AW-1:0]    pa_q, mid_q, chosen_q;
  wis_pkg::status_e status_q;

  logic                      out_valid_q;
  logic [wis_pkg::IDX_W-1:0] out_chosen_q;
  wis_pkg::status_e          out_status_q;
  wis_pkg::sum_t             out_total_q;
  logic [wis_pkg::CNT_W-1:0] out_count_q;

  logic [AW-1:0] idx_a;
  logic          is_rm;
  logic          sweep_go;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_w;
  wis_pkg::sum_t old_w;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_ra, mem_wa;
  wis_pkg::sum_t mem_wd;
  logic [XW-1:0] chosen_x, count_x;

  assign idx_a    = idx_q[AW-1:0];
  assign is_rm    = (op_q == wis_pkg::OP_REMOVE);
  assign sweep_go = (ptr_q < count_q);
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w    = mid_sum[CW:1];
  assign old_w    = rdata_q - prior_q;

  // one read port: prior sum, entry sum, sweep, search probe
  always_comb begin
    mem_re = 1'b1;
    mem_ra = idx_a;
    priority if (cmd_i.rd_prior) begin
      mem_ra = idx_a - AW'(1);
    end else if (cmd_i.rd_entry) begin
      mem_ra = idx_a;
    end else if (cmd_i.sweep_step && sweep_go) begin
      mem_ra = ptr_q[AW-1:0];
    end else if (cmd_i.srch_rd) begin
      mem_ra = mid_w[AW-1:0];
    end else begin
      mem_re = 1'b0;
    end
  end

  // one write port: append at the end, or sweep write-back one behind the read
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pa_q - AW'(is_rm);
    mem_wd = rdata_q + delta_q;
    if (cmd_i.append) begin
      mem_we = 1'b1;
      mem_wa = count_q[AW-1:0];
      mem_wd = total_q + wgt_q;
    end else if (cmd_i.sweep_step && pv_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= wis_pkg::opcode_e'(in_opcode_i);
      idx_q    <= XW'(in_index_i);
      wgt_q    <= SW'(in_weight_i) & WMASK;
      draw_q   <= in_draw_i;
      chosen_q <= '0;
    end
    if (cmd_i.status_we) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.append) begin
      chosen_q <= count_q[AW-1:0];
    end
    if (cmd_i.rd_entry) begin
      prior_q <= (idx_q == '0) ? '0 : rdata_q;
    end
    if (cmd_i.delta_init) begin
      // remove shifts the suffix down, so the sweep starts one past the entry
      delta_q <= is_rm ? (SW'(0) - old_w) : (wgt_q - old_w);
      ptr_q   <= idx_q[CW-1:0] + CW'(is_rm);
    end
    if (cmd_i.sweep_step && sweep_go) begin
      ptr_q <= ptr_q + CW'(1);
      pa_q  <= ptr_q[AW-1:0];
    end
    if (cmd_i.srch_init) begin
      lo_q <= '0;
      hi_q <= count_q;
    end
    if (cmd_i.srch_rd) begin
      mid_q <= mid_w[AW-1:0];
    end
    if (cmd_i.srch_cmp) begin
      if (rdata_q <= draw_q) begin
        lo_q <= CW'(mid_q) + CW'(1);
      end else begin
        hi_q <= CW'(mid_q);
      end
    end
    if (cmd_i.srch_done) begin
      chosen_q <= lo_q[AW-1:0];
    end
  end

  // table state and sweep pipeline flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      pv_q    <= 1'b0;
    end else begin
      pv_q <= cmd_i.sweep_step && sweep_go;
      if (cmd_i.append) begin
        count_q <= count_q + CW'(1);
        total_q <= total_q + wgt_q;
      end else if (cmd_i.commit) begin
        count_q <= count_q - CW'(is_rm);
        total_q <= total_q + delta_q;
      end
    end
  end

  assign chosen_x = XW'(chosen_q);
  assign count_x  = XW'(count_q);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_chosen_q <= chosen_x[wis_pkg::IDX_W-1:0];
      out_status_q <= status_q;
      out_total_q  <= total_q;
      out_count_q  <= count_x[wis_pkg::CNT_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_chosen_o = out_chosen_q;
  assign out_status_o = out_status_q;
  assign out_total_o  = out_total_q;
  assign out_count_o  = out_count_q;

  always_comb begin
    stat_o.op         = op_q;
    stat_o.full       = (count_q == FULL_CNT);
    stat_o.idx_bad    = (idx_q >= count_x);
    stat_o.empty      = (count_q == '0) || (total_q == '0);
    stat_o.draw_big   = (draw_q >= total_q);
    stat_o.sweep_done = !sweep_go && !pv_q;
    stat_o.srch_done  = (lo_q >= hi_q);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

// File: rtl/core/weighted_index_sampler.sv
`timescale 1ns / 1ps
// top level of the weighted index sampler
//
//   channel   direction  tdata (low bit up)                        tuser
//   s_axis    in         entry_index, weight, draw, zero pad       opcode
//   m_axis    out        chosen_index, total_weight, count, pad    status
//
// append writes the new sum at the end of the table; update and remove read the prior
//   and entry sums, then sweep to the last entry, one read-modify-write of the sum
//   memory per cycle; sample runs a binary search, with a memory read and a compare
//   for each step
// reset clears count and total at once; the count bounds the entry, sweep and search reads
// a finished result waits in the output register while the next word is taken
module weighted_index_sampler #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned WEIGHT_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // entry_index, weight, draw, zero pad
  input  logic [wis_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // opcode
  input  logic [wis_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // chosen_index, total_weight, count, zero pad
  output logic [wis_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // status
  output logic [wis_pkg::ST_W-1:0]          m_axis_tuser
);

  localparam int unsigned IDX_LO  = 0;
  localparam int unsigned WGT_LO  = IDX_LO + wis_pkg::IDX_W;
  localparam int unsigned DRAW_LO = WGT_LO + wis_pkg::WGT_W;
  localparam int unsigned OUT_PAD = wis_pkg::OUT_DATA_W - wis_pkg::IDX_W - wis_pkg::SUM_W
                                    - wis_pkg::CNT_W;

  wis_pkg::cmd_t     cmd;
  wis_pkg::dp_stat_t stat;

  logic [wis_pkg::IDX_W-1:0] out_chosen;
  wis_pkg::status_e          out_status;
  logic [wis_pkg::SUM_W-1:0] out_total;
  logic [wis_pkg::CNT_W-1:0] out_count;

  wis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wis_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_opcode_i  (s_axis_tuser),
    .in_index_i   (s_axis_tdata[WGT_LO-1:IDX_LO]),
    .in_weight_i  (s_axis_tdata[DRAW_LO-1:WGT_LO]),
    .in_draw_i    (s_axis_tdata[DRAW_LO+wis_pkg::SUM_W-1:DRAW_LO]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_chosen_o (out_chosen),
    .out_status_o (out_status),
    .out_total_o  (out_total),
    .out_count_o  (out_count)
  );

  assign m_axis_tdata = {{OUT_PAD{1'b0}}, out_count, out_total, out_chosen};
  assign m_axis_tuser = out_status;

endmodule

// File: rtl/core/wis_checker.sv
`timescale 1ns / 1ps
// port checker of the weighted index sampler and its bind
`include "weighted_index_sampler_macros.svh"

module wis_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [wis_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [wis_pkg::ST_W-1:0]       m_axis_tuser
);

  localparam int unsigned TOT_LO = wis_pkg::IDX_W;
  localparam int unsigned CNT_LO = TOT_LO + wis_pkg::SUM_W;

  logic [wis_pkg::IDX_W-1:0]                 out_chosen;
  logic [wis_pkg::SUM_W-1:0]                 out_total;
  logic [wis_pkg::CNT_W-1:0]                 out_count;
  logic [wis_pkg::OUT_DATA_W+wis_pkg::ST_W-1:0] out_word;
  logic                                      stall;
  logic                                      is_fail;
  logic                                      is_empty;
  logic                                      is_draw;
  logic                                      no_weight;

  assign out_chosen = m_axis_tdata[wis_pkg::IDX_W-1:0];
  assign out_total  = m_axis_tdata[CNT_LO-1:TOT_LO];
  assign out_count  = m_axis_tdata[CNT_LO+wis_pkg::CNT_W-1:CNT_LO];
  assign out_word   = {m_axis_tuser, m_axis_tdata};
  assign stall      = m_axis_tvalid && !m_axis_tready;
  assign is_fail    = m_axis_tvalid && (m_axis_tuser != wis_pkg::ST_OK);
  assign is_empty   = m_axis_tvalid && (m_axis_tuser == wis_pkg::ST_EMPTY);
  assign is_draw    = m_axis_tvalid && (m_axis_tuser == wis_pkg::ST_DRAW);
  assign no_weight  = (out_count == '0) || (out_total == '0);

  `WIS_ASSERT_NXT(a_out_hold, stall, m_axis_tvalid && $stable(out_word), "word changed in stall")

  `WIS_ASSERT_IMP(a_err_chosen_zero, is_fail, out_chosen == '0, "failed word with nonzero index")

  `WIS_ASSERT_IMP(a_empty_means_empty, is_empty, no_weight, "empty status with entries and weight")

  `WIS_ASSERT_IMP(a_draw_has_total, is_draw, out_total != '0, "draw status with zero total")

endmodule

bind weighted_index_sampler wis_checker u_wis_checker (.*);
